[rtl/core/bit_string_set_table_unit_macros.svh]
// Assertion macros shared by the set table RTL.
`ifndef BIT_STRING_SET_TABLE_UNIT_MACROS_SVH
`define BIT_STRING_SET_TABLE_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bst_pkg.sv]
// Package with codes, widths and the result type of the set table.
`default_nettype none

package bst_pkg;

    localparam int DEF_MAX_ELEMENTS = 64;
    localparam int DEF_ELEM_WIDTH   = 32;

    localparam int CMD_W   = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEMBER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        logic [COUNT_W-1:0] element_count;
        logic [VAL_W-1:0]   read_data;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/bst_mem.sv]
// Single-port element store with a registered read.
`default_nettype none

module bst_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            store_reg[addr] <= wdata;
        end
        else if (en)
        begin
            rdata_reg <= store_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/bst_ctrl.sv]
// Command sequencer of the set table: search, append, gap closing and read.
`default_nettype none

module bst_ctrl #(
    parameter int MAX_ELEMENTS = 64,
    parameter int SW           = 32,
    parameter int AW           = 6,
    parameter int CNT_W        = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire logic [bst_pkg::CMD_W-1:0]   command,
    input  wire logic [bst_pkg::VAL_W-1:0]   element_value,
    input  wire logic [bst_pkg::POS_W-1:0]   position,
    output logic                             res_vld,
    input  wire logic                        res_rdy,
    output bst_pkg::res_t                    res,
    output logic                             mem_en,
    output logic                             mem_we,
    output logic      [AW-1:0]               mem_addr,
    output logic      [SW-1:0]               mem_wdata,
    input  wire logic [SW-1:0]               mem_rdata
);
    import bst_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHR    = 3'd2;
    localparam logic [2:0] S_SHW    = 3'd3;
    localparam logic [2:0] S_RDW    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [SW-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     data_reg, data_next;

    logic [CNT_W-1:0]   idx_inc;
    logic               hit;
    logic               pos_ok;
    logic [CNT_W+6:0]   count_ext;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign hit     = cmp_vld_reg && (mem_rdata == val_reg);
    assign pos_ok  = (position != '0) && (CMP_W'(position) <= CMP_W'(count_reg));

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        data_next    = data_reg;
        mem_en       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = idx_reg[AW-1:0];
        mem_wdata    = val_reg;
        cmd_ready    = 1'b0;
        res_vld      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next    = command;
                    val_next    = element_value[SW-1:0];
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    data_next   = '0;
                    if (command == CMD_READ)
                    begin
                        if (pos_ok)
                        begin
                            mem_en     = 1'b1;
                            mem_addr   = AW'(position - POS_W'(1));
                            state_next = S_RDW;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            status_next = ST_PRESENT;
                            state_next  = S_DONE;
                        end
                        CMD_REMOVE:
                        begin
                            idx_next   = cmp_idx_reg;
                            state_next = S_SHR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (idx_reg < count_reg)
                begin
                    // Reads are issued back to back; each compare lands in the cycle after its read.
                    mem_en       = 1'b1;
                    mem_addr     = idx_reg[AW-1:0];
                    idx_next     = idx_inc;
                    cmp_idx_next = idx_reg;
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(MAX_ELEMENTS))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_en     = 1'b1;
                            mem_we     = 1'b1;
                            mem_addr   = count_reg[AW-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_SHR:
            begin
                if (idx_inc < count_reg)
                begin
                    mem_en     = 1'b1;
                    mem_addr   = idx_inc[AW-1:0];
                    state_next = S_SHW;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SHW:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = S_SHR;
            end
            S_RDW:
            begin
                data_next  = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_vld = 1'b1;
                if (res_rdy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        data_reg    <= data_next;
    end

    assign count_ext         = {7'd0, count_reg};
    assign res.status        = status_reg;
    assign res.found         = found_reg;
    assign res.element_count = count_ext[COUNT_W-1:0];
    assign res.read_data     = VAL_W'(data_reg);

endmodule

`default_nettype wire

[rtl/core/bit_string_set_table_unit.sv]
// Top level of the ordered set table: command channel, result register and element store.
//
// The command channel (cmd_valid, cmd_stall) carries one transaction per command:
// insert, remove, member query or read by 1-based position. Each command gives
// exactly one result transaction on the result channel (res_valid, res_stall)
// with a status, a found flag, the element count after the command and read data.
// The elements live in a single-port memory with a registered read. Commands are
// handled one at a time; the memory port sets the time per command. A member query
// or an insert searches the stored elements, a read does a single memory read, and
// a remove searches up to the element and then moves each later element down to
// close the gap, with a read and a write for each. The next command is accepted in
// the cycle after the result register loads, and the next command is accepted
// while the finished result waits. cmd_stall is high while a command is in
// progress; a result held by res_stall holds back only the following result.
// Reset empties the set at once; no memory clearing pass is needed because only
// entries below the element count are ever read.
`default_nettype none

module bit_string_set_table_unit #(
    parameter int MAX_ELEMENTS = bst_pkg::DEF_MAX_ELEMENTS,
    parameter int ELEM_WIDTH   = bst_pkg::DEF_ELEM_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire logic [bst_pkg::CMD_W-1:0]     command,
    input  wire logic [bst_pkg::VAL_W-1:0]     element_value,
    input  wire logic [bst_pkg::POS_W-1:0]     position,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic      [bst_pkg::STAT_W-1:0]    status,
    output logic                               found,
    output logic      [bst_pkg::COUNT_W-1:0]   element_count,
    output logic      [bst_pkg::VAL_W-1:0]     read_data
);
    import bst_pkg::*;

    // Only the low bits that both the element width and the input field carry matter.
    localparam int SW    = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic          cmd_ready;
    logic          res_vld;
    logic          res_rdy;
    res_t          res;
    logic          mem_en;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [SW-1:0] mem_wdata;
    logic [SW-1:0] mem_rdata;

    logic          out_vld_reg, out_vld_next;
    res_t          out_reg;

    bst_mem #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (SW),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bst_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .SW           (SW),
        .AW           (AW),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .element_value (element_value),
        .position      (position),
        .res_vld       (res_vld),
        .res_rdy       (res_rdy),
        .res           (res),
        .mem_en        (mem_en),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    assign cmd_stall = !cmd_ready;

    // The output register takes a new result when it is empty or being drained.
    assign res_rdy = !out_vld_reg || !res_stall;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_vld && res_rdy)
        begin
            out_vld_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld && res_rdy)
        begin
            out_reg <= res;
        end
    end

    assign res_valid     = out_vld_reg;
    assign status        = out_reg.status;
    assign found         = out_reg.found;
    assign element_count = out_reg.element_count;
    assign read_data     = out_reg.read_data;

`include "bit_string_set_table_unit_macros.svh"

    // A result handed over by the sequencer shows up on the result channel next cycle.
    `BST_ASSERT_NEXT(a_res_lands, res_vld && res_rdy, res_valid, "result lost in output register")
    // An accepted command keeps the command channel stalled in the cycle after it is taken.
    `BST_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "command not held busy")
    // Found is set only for a present element on insert, remove or member.
    `BST_ASSERT_NOW(a_found_status, res_valid && found, status == ST_OK || status == ST_PRESENT, "found with bad status")
    // A read outside the set returns zero data.
    `BST_ASSERT_NOW(a_range_zero, res_valid && status == ST_RANGE, read_data == '0 && !found, "range error with data")

endmodule

`default_nettype wire
